### src/crcc_pkg.sv
// Shared types, constants and helper functions of the column run color classifier.
// No dependencies; every other file imports this package.
package crcc_pkg;

    localparam int MAX_SKIP_DEF    = 5;
    localparam int COLUMN_ROWS_DEF = 256;
    localparam int MAX_RES         = 6;
    localparam int NUM_CUBES       = 5;
    localparam logic [7:0] LIMIT_RESET = 8'd40;

    // configuration register indexes
    localparam logic [2:0] CFG_WHITE  = 3'd0;
    localparam logic [2:0] CFG_GREEN  = 3'd1;
    localparam logic [2:0] CFG_BLUE   = 3'd2;
    localparam logic [2:0] CFG_YELLOW = 3'd3;
    localparam logic [2:0] CFG_ORANGE = 3'd4;
    localparam logic [2:0] CFG_LIMIT  = 3'd5;

    // color class codes
    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_WHITE  = 3'd1;
    localparam logic [2:0] CLS_GREEN  = 3'd2;
    localparam logic [2:0] CLS_BLUE   = 3'd3;
    localparam logic [2:0] CLS_YELLOW = 3'd4;
    localparam logic [2:0] CLS_ORANGE = 3'd5;

    localparam logic [2:0] CUBE_CLASS [NUM_CUBES] =
        '{CLS_WHITE, CLS_GREEN, CLS_BLUE, CLS_YELLOW, CLS_ORANGE};

    typedef logic [NUM_CUBES-1:0][47:0] cube_arr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIM,
        ST_FEED,
        ST_NEXT,
        ST_DIV,
        ST_RES,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load_input;
        logic calc_lim;
        logic feed;
        logic load_replay;
        logic close_end;
        logic finish;
        logic emit;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic feed_close;
        logic rep_more;
        logic run_open;
        logic end_flag;
        logic div_done;
        logic res_room;
        logic pend_valid;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic       last_result;
        logic [9:0] run_column;
        logic [8:0] end_row;
        logic [7:0] start_row;
        logic [7:0] avg_red_diff;
        logic [7:0] avg_blue_diff;
        logic [7:0] avg_luma;
        logic [2:0] color_class;
    } res_t;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        absdiff8 = (a > b) ? (a - b) : (b - a);
    endfunction

    // first cube in list order that holds the average wins
    function automatic logic [2:0] classify(input cube_arr_t cubes, input logic [7:0] y,
                                            input logic [7:0] cb, input logic [7:0] cr);
        logic [2:0] cls;
        logic [47:0] c;
        cls = CLS_NONE;
        for (int i = NUM_CUBES - 1; i >= 0; i--)
        begin
            c = cubes[i];
            if (y >= c[7:0] && y <= c[15:8] && cb >= c[23:16] && cb <= c[31:24] &&
                cr >= c[39:32] && cr <= c[47:40])
            begin
                cls = CUBE_CLASS[i];
            end
        end
        classify = cls;
    endfunction

endpackage

### src/column_run_color_classifier.sv
// Column run color classifier: cuts a column of YCbCr pixels into similar runs and
// classifies each run's average against five color cubes.
// One pixel is taken at a time, through accept, limit, feed and decide steps; each replayed
// tail pixel repeats limit, feed and decide; a run close adds divider and result steps; a
// pixel with results ends in a hand-off step, where its last result leaves.
// Reset (rst_n, async, low): no run open, row 0, cubes 0, limit 40; tail not cleared.
module column_run_color_classifier import crcc_pkg::*; #(
    parameter int MAX_SKIP    = MAX_SKIP_DEF,
    parameter int COLUMN_ROWS = COLUMN_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // luma[7:0], blue_diff[15:8], red_diff[23:16],
                                       // column_index[33:24], zero pad [39:34]
    input  logic        s_axis_tlast,  // last_of_column
    // run result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // color_class[2:0], avg_luma[10:3],
                                       // avg_blue_diff[18:11], avg_red_diff[26:19],
                                       // start_row[34:27], end_row[43:35],
                                       // run_column[53:44], zero pad [55:54]
    output logic        m_axis_tlast,  // last_result
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    cube_arr_t  cube_reg;
    logic [7:0] limit_reg;
    cmd_t       cmd;
    stat_t      stat;
    logic       res_valid;
    res_t       res;

    // Configuration must be written only while idle; the block does not enforce it and always takes the transaction.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_reg  <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            // indexes above the limit register are dropped
            if (cfg_index == CFG_LIMIT)
                limit_reg <= cfg_data[7:0];
            else if (cfg_index <= CFG_ORANGE)
                cube_reg[cfg_index] <= cfg_data;
        end
    end

    // Controller: owns the sequence of feed, replay, close and hand-off steps.
    crcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: run state, tail buffer, divider and the result registers.
    crcc_dp #(
        .MAX_SKIP    (MAX_SKIP),
        .COLUMN_ROWS (COLUMN_ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_luma      (s_axis_tdata[7:0]),
        .in_blue_diff (s_axis_tdata[15:8]),
        .in_red_diff  (s_axis_tdata[23:16]),
        .in_column    (s_axis_tdata[33:24]),
        .in_last      (s_axis_tlast),
        .cubes        (cube_reg),
        .sim_limit    (limit_reg),
        .out_ready    (m_axis_tready),
        .out_valid    (res_valid),
        .out_data     (res)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tvalid = res_valid;
    assign m_axis_tlast  = res.last_result;
    assign m_axis_tdata  = {2'b00, res.run_column, res.end_row, res.start_row,
                            res.avg_red_diff, res.avg_blue_diff, res.avg_luma,
                            res.color_class};

endmodule

### src/crcc_div.sv
// Multi-cycle divider: three channel sums over one shared pixel count, one quotient bit a cycle.
// Depends on crcc_pkg.
module crcc_div import crcc_pkg::*; #(
    parameter int CNT_W = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2:0][CNT_W+7:0]   sums,
    input  logic [CNT_W-1:0]        count,
    input  logic [23:0]             ref_pix,
    output logic [2:0][7:0]         quot,
    output logic                    done
);
    localparam int SUM_W = CNT_W + 8;

    logic [2:0][SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]      dsh_reg, dsh_next;
    logic [2:0][7:0]       q_reg, q_next;
    logic [2:0]            bit_reg, bit_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            if (count == '0)
            begin
                // empty run: average is the start pixel
                q_next    = {ref_pix[23:16], ref_pix[15:8], ref_pix[7:0]};
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = sums;
                dsh_next  = SUM_W'({count, 7'b0});
                q_next    = '0;
                bit_next  = 3'd7;
                busy_next = 1'b1;
                done_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                if (rem_reg[ch] >= dsh_reg)
                begin
                    rem_next[ch]        = rem_reg[ch] - dsh_reg;
                    q_next[ch][bit_reg] = 1'b1;
                end
            end
            dsh_next = dsh_reg >> 1;
            bit_next = bit_reg - 3'd1;
            if (bit_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

### src/crcc_ctrl.sv
// Controller state machine: sequences feed, tail replay, run close, division and result hand-off.
// Depends on crcc_pkg; drives the datapath through cmd_t and reads stat_t.
module crcc_ctrl import crcc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_input = 1'b1;
                    state_next     = ST_LIM;
                end
            end
            ST_LIM:
            begin
                cmd.calc_lim = 1'b1;
                state_next   = ST_FEED;
            end
            ST_FEED:
            begin
                cmd.feed   = 1'b1;
                state_next = stat.feed_close ? ST_DIV : ST_NEXT;
            end
            ST_NEXT:
            begin
                priority if (stat.rep_more)
                begin
                    cmd.load_replay = 1'b1;
                    state_next      = ST_LIM;
                end
                else if (stat.end_flag && stat.run_open)
                begin
                    cmd.close_end = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = stat.pend_valid ? ST_FIN : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_RES;
            end
            ST_RES:
            begin
                priority if (!stat.res_room)
                    state_next = ST_NEXT;
                else if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_NEXT;
                end
                else
                    state_next = ST_RES;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    ast_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_input |=> state_reg == ST_LIM)
        else $error("accepted pixel did not start a feed");

endmodule

### src/crcc_dp.sv
// Datapath: run state, tail buffer, similarity test, sums, divider and result registers.
// Depends on crcc_pkg and crcc_div; commanded by crcc_ctrl.
module crcc_dp import crcc_pkg::*; #(
    parameter int MAX_SKIP    = MAX_SKIP_DEF,
    parameter int COLUMN_ROWS = COLUMN_ROWS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output stat_t      stat,
    input  logic [7:0] in_luma,
    input  logic [7:0] in_blue_diff,
    input  logic [7:0] in_red_diff,
    input  logic [9:0] in_column,
    input  logic       in_last,
    input  cube_arr_t  cubes,
    input  logic [7:0] sim_limit,
    input  logic       out_ready,
    output logic       out_valid,
    output res_t       out_data
);
    localparam int ROW_W = $clog2(COLUMN_ROWS + 1);
    localparam int CNT_W = $clog2(COLUMN_ROWS);
    localparam int SUM_W = CNT_W + 8;
    localparam int MW    = $clog2(MAX_SKIP + 1);
    localparam int TIX_W = (MAX_SKIP > 1) ? $clog2(MAX_SKIP) : 1;

    logic [23:0]            ref_reg, ref_next;
    logic [7:0]             cblim_reg, cblim_next;
    logic [23:0]            cur_reg, cur_next;
    logic [ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]       in_row_reg, in_row_next;
    logic [9:0]             col_reg, col_next;
    logic                   end_flag_reg, end_flag_next;
    logic                   run_open_reg, run_open_next;
    logic [ROW_W-1:0]       start_reg, start_next;
    logic [ROW_W-1:0]       row_cnt_reg, row_cnt_next;
    logic [MW-1:0]          miss_reg, miss_next;
    logic [2:0][SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [23:0]            tail_reg [MAX_SKIP];
    logic [MW-1:0]          rep_n_reg, rep_n_next;
    logic [MW-1:0]          rep_idx_reg, rep_idx_next;
    logic [ROW_W-1:0]       rep_end_reg, rep_end_next;
    logic [ROW_W-1:0]       res_start_reg, res_start_next;
    logic [ROW_W-1:0]       res_end_reg, res_end_next;
    logic [2:0]             res_cnt_reg, res_cnt_next;
    res_t                   pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    res_t                   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   similar;
    logic                   feed_close;
    logic                   close_any;
    logic                   tail_we;
    logic [ROW_W-1:0]       end_val;
    logic [15:0]            lim_prod;
    logic [16:0]            lim_quot;
    logic [ROW_W:0]         row_inc;
    logic [2:0][7:0]        quot;
    logic                   div_done;
    res_t                   new_res;
    logic [31:0]            start_wide;
    logic [31:0]            end_wide;

    crcc_div #(.CNT_W(CNT_W)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (close_any),
        .sums    (sum_reg),
        .count   (cnt_reg),
        .ref_pix (ref_reg),
        .quot    (quot),
        .done    (div_done)
    );

    assign similar = (absdiff8(ref_reg[7:0],   cur_reg[7:0])   <= sim_limit) &&
                     (absdiff8(ref_reg[15:8],  cur_reg[15:8])  <= cblim_reg) &&
                     (absdiff8(ref_reg[23:16], cur_reg[23:16]) <= sim_limit);
    assign feed_close = run_open_reg && !similar && ((miss_reg + MW'(1)) >= MW'(MAX_SKIP));
    assign close_any  = (cmd.feed && feed_close) || cmd.close_end;
    assign end_val    = cmd.close_end ? (in_row_reg + ROW_W'(1) - ROW_W'(miss_reg))
                                      : (cur_row_reg + ROW_W'(1) - ROW_W'(MAX_SKIP));
    assign tail_we    = cmd.feed && run_open_reg && !similar && (miss_reg < MW'(MAX_SKIP));

    // floor(L*(255-cr)/255) by reciprocal: exact for 16-bit products
    assign lim_prod = 16'(sim_limit) * 16'(8'd255 - ref_reg[23:16]);
    assign lim_quot = 17'(lim_prod) + 17'(lim_prod >> 8) + 17'd1;
    assign row_inc  = (ROW_W+1)'(row_cnt_reg) + (ROW_W+1)'(1);

    assign start_wide = 32'(res_start_reg);
    assign end_wide   = 32'(res_end_reg);

    always_comb
    begin
        new_res               = '0;
        new_res.color_class   = classify(cubes, quot[0], quot[1], quot[2]);
        new_res.avg_luma      = quot[0];
        new_res.avg_blue_diff = quot[1];
        new_res.avg_red_diff  = quot[2];
        new_res.start_row     = start_wide[7:0];
        new_res.end_row       = end_wide[8:0];
        new_res.run_column    = col_reg;
        new_res.last_result   = 1'b0;
    end

    always_comb
    begin
        ref_next        = ref_reg;
        cblim_next      = cblim_reg;
        cur_next        = cur_reg;
        cur_row_next    = cur_row_reg;
        in_row_next     = in_row_reg;
        col_next        = col_reg;
        end_flag_next   = end_flag_reg;
        run_open_next   = run_open_reg;
        start_next      = start_reg;
        row_cnt_next    = row_cnt_reg;
        miss_next       = miss_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        rep_n_next      = rep_n_reg;
        rep_idx_next    = rep_idx_reg;
        rep_end_next    = rep_end_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        res_cnt_next    = res_cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.load_input)
        begin
            cur_next      = {in_red_diff, in_blue_diff, in_luma};
            cur_row_next  = row_cnt_reg;
            in_row_next   = row_cnt_reg;
            col_next      = in_column;
            end_flag_next = in_last || (row_inc >= (ROW_W+1)'(COLUMN_ROWS));
            rep_n_next    = '0;
            rep_idx_next  = '0;
            res_cnt_next  = '0;
        end

        if (cmd.calc_lim)
            cblim_next = lim_quot[15:8];

        if (cmd.load_replay)
        begin
            cur_next     = tail_reg[rep_idx_reg[TIX_W-1:0]];
            cur_row_next = rep_end_reg + ROW_W'(rep_idx_reg);
            rep_idx_next = rep_idx_reg + MW'(1);
        end

        if (cmd.feed)
        begin
            priority if (!run_open_reg)
            begin
                run_open_next = 1'b1;
                ref_next      = cur_reg;
                start_next    = cur_row_reg;
                miss_next     = '0;
                cnt_next      = '0;
                sum_next      = '0;
            end
            else if (similar)
            begin
                for (int ch = 0; ch < 3; ch++)
                    sum_next[ch] = sum_reg[ch] + SUM_W'(cur_reg[8*ch +: 8]);
                cnt_next  = cnt_reg + CNT_W'(1);
                ref_next  = cur_reg;
                miss_next = '0;
            end
            else
                miss_next = miss_reg + MW'(1);
        end

        // close: hold the run's rows, arm the tail replay, start the average
        if (close_any)
        begin
            res_start_next = start_reg;
            res_end_next   = end_val;
            rep_end_next   = end_val;
            rep_n_next     = cmd.close_end ? miss_reg : MW'(MAX_SKIP);
            rep_idx_next   = MW'(1);
            run_open_next  = 1'b0;
            miss_next      = '0;
        end

        if (cmd.finish)
        begin
            if (end_flag_reg)
            begin
                row_cnt_next = '0;
                miss_next    = '0;
                cnt_next     = '0;
            end
            else
                row_cnt_next = row_inc[ROW_W-1:0];
        end

        if (cmd.emit)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = new_res;
            pend_valid_next = 1'b1;
            res_cnt_next    = res_cnt_reg + 3'd1;
        end

        if (cmd.flush)
        begin
            out_next             = pend_reg;
            out_next.last_result = 1'b1;
            out_valid_next       = 1'b1;
            pend_valid_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg        <= '0;
            end_flag_reg   <= 1'b0;
            run_open_reg   <= 1'b0;
            start_reg      <= '0;
            row_cnt_reg    <= '0;
            miss_reg       <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            rep_n_reg      <= '0;
            rep_idx_reg    <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ref_reg        <= ref_next;
            end_flag_reg   <= end_flag_next;
            run_open_reg   <= run_open_next;
            start_reg      <= start_next;
            row_cnt_reg    <= row_cnt_next;
            miss_reg       <= miss_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            rep_n_reg      <= rep_n_next;
            rep_idx_reg    <= rep_idx_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cblim_reg     <= cblim_next;
        cur_reg       <= cur_next;
        cur_row_reg   <= cur_row_next;
        in_row_reg    <= in_row_next;
        col_reg       <= col_next;
        rep_end_reg   <= rep_end_next;
        res_start_reg <= res_start_next;
        res_end_reg   <= res_end_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        if (tail_we)
            tail_reg[miss_reg[TIX_W-1:0]] <= cur_reg;
    end

    always_comb
    begin
        stat            = '0;
        stat.feed_close = feed_close;
        stat.rep_more   = rep_idx_reg < rep_n_reg;
        stat.run_open   = run_open_reg;
        stat.end_flag   = end_flag_reg;
        stat.div_done   = div_done;
        stat.res_room   = res_cnt_reg < 3'(MAX_RES);
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    ast_miss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        miss_reg < MW'(MAX_SKIP))
        else $error("miss count reached the skip limit without a close");

    ast_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= 3'(MAX_RES))
        else $error("more results counted than allowed per pixel");

    ast_pend_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pend_valid_reg) |-> out_valid_reg && out_reg.last_result)
        else $error("pending result dropped without a last-marked hand-off");

endmodule
